@@ src/aic_pkg.sv @@
// Shared types, constants and helper functions of the ARP and ICMP echo frame classifier.
package aic_pkg;

  // Byte counter width and its default.
  localparam int unsigned OFFSET_WIDTH_DEFAULT = 11;

  // Configuration port geometry and register indexes.
  localparam int unsigned APB_DATA_WIDTH = 32;
  localparam int unsigned APB_ADDR_WIDTH = 3;
  localparam logic        REG_LOCAL_IP   = 1'b0;

  // Reset value of our IPv4 address: 172.22.26.219.
  localparam logic [31:0] LOCAL_IP_RESET = {8'd172, 8'd22, 8'd26, 8'd219};

  // Ethertypes and fixed header values.
  localparam logic [15:0] ETYPE_ARP       = 16'h0806;
  localparam logic [15:0] ETYPE_IPV4      = 16'h0800;
  localparam logic [7:0]  IPV4_FIRST_BYTE = 8'h45;
  localparam logic [7:0]  DF_ONLY_MASK    = 8'hBF;
  localparam logic [7:0]  IP_PROTO_ICMP   = 8'd1;
  localparam logic [7:0]  ICMP_ECHO_REQ   = 8'd8;
  localparam logic [15:0] IPV4_HDR_BYTES  = 16'd20;

  // Byte offsets within the frame.
  localparam int unsigned OFF_ETYPE_HI    = 12;
  localparam int unsigned OFF_ETYPE_LO    = 13;
  localparam int unsigned OFF_ARP_FIX_LO  = 14;
  localparam int unsigned OFF_ARP_FIX_HI  = 21;
  localparam int unsigned OFF_ARP_SHA_LO  = 22;
  localparam int unsigned OFF_ARP_SHA_HI  = 27;
  localparam int unsigned OFF_ARP_SPA_LO  = 28;
  localparam int unsigned OFF_ARP_SPA_HI  = 31;
  localparam int unsigned OFF_ARP_TPA_LO  = 38;
  localparam int unsigned OFF_ARP_TPA_HI  = 41;
  localparam int unsigned OFF_IP_VER      = 14;
  localparam int unsigned OFF_IP_LEN_HI   = 16;
  localparam int unsigned OFF_IP_LEN_LO   = 17;
  localparam int unsigned OFF_IP_FLAGS_HI = 20;
  localparam int unsigned OFF_IP_FLAGS_LO = 21;
  localparam int unsigned OFF_IP_PROTO    = 23;
  localparam int unsigned OFF_IP_SRC_LO   = 26;
  localparam int unsigned OFF_IP_SRC_HI   = 29;
  localparam int unsigned OFF_IP_DST_LO   = 30;
  localparam int unsigned OFF_IP_DST_HI   = 33;
  localparam int unsigned OFF_ICMP_TYPE   = 34;

  // Offsets of the last byte of the shortest frames that pass the length checks (42 and 34 bytes).
  localparam int unsigned ARP_MIN_LAST_OFF  = 41;
  localparam int unsigned IPV4_MIN_LAST_OFF = 33;

  // Verdict codes.
  typedef enum logic [1:0] {
    ACT_IGNORE = 2'd0,
    ACT_ARP    = 2'd1,
    ACT_ECHO   = 2'd2
  } action_e;

  // One accepted byte handed to the parser.
  typedef struct packed {
    logic       valid;
    logic       last;
    logic [7:0] data;
  } aic_beat_t;

  // Verdict produced at the last byte of a frame.
  typedef struct packed {
    action_e     action;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [15:0] echo_length;
  } aic_verdict_t;

  // Expected ARP bytes 14..21: Ethernet, IPv4, lengths 6 and 4, request.
  function automatic logic [7:0] arp_fixed_byte(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0:    val = 8'h00;
      3'd1:    val = 8'h01;
      3'd2:    val = 8'h08;
      3'd3:    val = 8'h00;
      3'd4:    val = 8'h06;
      3'd5:    val = 8'h04;
      3'd6:    val = 8'h00;
      3'd7:    val = 8'h01;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

@@ src/aic_if.sv @@
// Valid/ready channel interfaces for received bytes and for verdicts.
interface aic_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface aic_verdict_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [47:0] sender_mac;
  logic [31:0] sender_ip;
  logic [15:0] echo_length;

  modport source (output valid, output action, output sender_mac, output sender_ip,
                  output echo_length, input ready);
  modport sink   (input valid, input action, input sender_mac, input sender_ip,
                  input echo_length, output ready);
endinterface

@@ src/aic_parser.sv @@
// Per-frame header parser: byte counter, field capture, checks and verdict logic.
module aic_parser #(
  parameter int unsigned OFFSET_WIDTH = aic_pkg::OFFSET_WIDTH_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  aic_pkg::aic_beat_t   beat_i,
  input  logic [31:0]          local_ip_i,
  output aic_pkg::aic_verdict_t verdict_o
);

  localparam logic [OFFSET_WIDTH-1:0] OFF_MAX = '1;

  // Frame state registers.
  logic [OFFSET_WIDTH-1:0] offset_q, offset_d;
  logic [15:0]             etype_q, etype_d;
  logic                    hdr_ok_q, hdr_ok_d;
  logic [47:0]             mac_q, mac_d;
  logic [31:0]             src_ip_q, src_ip_d;
  logic [31:0]             dst_ip_q, dst_ip_d;
  logic [15:0]             ip_len_q, ip_len_d;
  logic [7:0]              ip_proto_q, ip_proto_d;
  logic [8:0]              icmp_type_q, icmp_type_d;

  // Field values after taking the current byte.
  logic [15:0] upd_etype;
  logic        upd_hdr_ok;
  logic [47:0] upd_mac;
  logic [31:0] upd_src_ip;
  logic [31:0] upd_dst_ip;
  logic [15:0] upd_ip_len;
  logic [7:0]  upd_ip_proto;
  logic [8:0]  upd_icmp_type;

  logic [OFFSET_WIDTH-1:0] o;
  logic [7:0]              b;
  logic                    arp_ok;
  logic                    echo_ok;

  assign o = offset_q;
  assign b = beat_i.data;

  // Capture or check the current byte according to its offset and the ethertype.
  always_comb begin
    upd_etype     = etype_q;
    upd_hdr_ok    = hdr_ok_q;
    upd_mac       = mac_q;
    upd_src_ip    = src_ip_q;
    upd_dst_ip    = dst_ip_q;
    upd_ip_len    = ip_len_q;
    upd_ip_proto  = ip_proto_q;
    upd_icmp_type = icmp_type_q;
    if (o == OFFSET_WIDTH'(aic_pkg::OFF_ETYPE_HI) ||
        o == OFFSET_WIDTH'(aic_pkg::OFF_ETYPE_LO)) begin
      upd_etype = {etype_q[7:0], b};
    end else if (etype_q == aic_pkg::ETYPE_ARP) begin
      if (o >= OFFSET_WIDTH'(aic_pkg::OFF_ARP_FIX_LO) &&
          o <= OFFSET_WIDTH'(aic_pkg::OFF_ARP_FIX_HI)) begin
        if (b != aic_pkg::arp_fixed_byte(o[2:0] - 3'(aic_pkg::OFF_ARP_FIX_LO))) begin
          upd_hdr_ok = 1'b0;
        end
      end else if (o >= OFFSET_WIDTH'(aic_pkg::OFF_ARP_SHA_LO) &&
                   o <= OFFSET_WIDTH'(aic_pkg::OFF_ARP_SHA_HI)) begin
        upd_mac = {mac_q[39:0], b};
      end else if (o >= OFFSET_WIDTH'(aic_pkg::OFF_ARP_SPA_LO) &&
                   o <= OFFSET_WIDTH'(aic_pkg::OFF_ARP_SPA_HI)) begin
        upd_src_ip = {src_ip_q[23:0], b};
      end else if (o >= OFFSET_WIDTH'(aic_pkg::OFF_ARP_TPA_LO) &&
                   o <= OFFSET_WIDTH'(aic_pkg::OFF_ARP_TPA_HI)) begin
        upd_dst_ip = {dst_ip_q[23:0], b};
      end
    end else if (etype_q == aic_pkg::ETYPE_IPV4) begin
      if (o == OFFSET_WIDTH'(aic_pkg::OFF_IP_VER)) begin
        if (b != aic_pkg::IPV4_FIRST_BYTE) begin
          upd_hdr_ok = 1'b0;
        end
      end else if (o == OFFSET_WIDTH'(aic_pkg::OFF_IP_LEN_HI) ||
                   o == OFFSET_WIDTH'(aic_pkg::OFF_IP_LEN_LO)) begin
        upd_ip_len = {ip_len_q[7:0], b};
      end else if (o == OFFSET_WIDTH'(aic_pkg::OFF_IP_FLAGS_HI)) begin
        if ((b & aic_pkg::DF_ONLY_MASK) != 8'h00) begin
          upd_hdr_ok = 1'b0;
        end
      end else if (o == OFFSET_WIDTH'(aic_pkg::OFF_IP_FLAGS_LO)) begin
        if (b != 8'h00) begin
          upd_hdr_ok = 1'b0;
        end
      end else if (o == OFFSET_WIDTH'(aic_pkg::OFF_IP_PROTO)) begin
        upd_ip_proto = b;
      end else if (o >= OFFSET_WIDTH'(aic_pkg::OFF_IP_SRC_LO) &&
                   o <= OFFSET_WIDTH'(aic_pkg::OFF_IP_SRC_HI)) begin
        upd_src_ip = {src_ip_q[23:0], b};
      end else if (o >= OFFSET_WIDTH'(aic_pkg::OFF_IP_DST_LO) &&
                   o <= OFFSET_WIDTH'(aic_pkg::OFF_IP_DST_HI)) begin
        upd_dst_ip = {dst_ip_q[23:0], b};
      end else if (o == OFFSET_WIDTH'(aic_pkg::OFF_ICMP_TYPE)) begin
        upd_icmp_type = {1'b1, b};
      end
    end
  end

  // Verdict from the fields as they stand after the last byte.
  assign arp_ok = (upd_etype == aic_pkg::ETYPE_ARP) &&
                  (o >= OFFSET_WIDTH'(aic_pkg::ARP_MIN_LAST_OFF)) &&
                  upd_hdr_ok && (upd_dst_ip == local_ip_i);
  assign echo_ok = (upd_etype == aic_pkg::ETYPE_IPV4) &&
                   (o >= OFFSET_WIDTH'(aic_pkg::IPV4_MIN_LAST_OFF)) &&
                   upd_hdr_ok && (upd_dst_ip == local_ip_i) &&
                   (upd_ip_proto == aic_pkg::IP_PROTO_ICMP) &&
                   (upd_icmp_type == {1'b1, aic_pkg::ICMP_ECHO_REQ});

  always_comb begin
    verdict_o = '{action: aic_pkg::ACT_IGNORE, sender_mac: '0, sender_ip: '0,
                  echo_length: '0};
    if (arp_ok) begin
      verdict_o.action     = aic_pkg::ACT_ARP;
      verdict_o.sender_mac = upd_mac;
      verdict_o.sender_ip  = upd_src_ip;
    end else if (echo_ok) begin
      verdict_o.action      = aic_pkg::ACT_ECHO;
      verdict_o.sender_ip   = upd_src_ip;
      verdict_o.echo_length = upd_ip_len - aic_pkg::IPV4_HDR_BYTES;
    end
  end

  // Next state: advance on each beat, clear after the last byte of a frame.
  always_comb begin
    offset_d    = offset_q;
    etype_d     = etype_q;
    hdr_ok_d    = hdr_ok_q;
    mac_d       = mac_q;
    src_ip_d    = src_ip_q;
    dst_ip_d    = dst_ip_q;
    ip_len_d    = ip_len_q;
    ip_proto_d  = ip_proto_q;
    icmp_type_d = icmp_type_q;
    if (beat_i.valid) begin
      if (beat_i.last) begin
        offset_d    = '0;
        etype_d     = '0;
        hdr_ok_d    = 1'b1;
        mac_d       = '0;
        src_ip_d    = '0;
        dst_ip_d    = '0;
        ip_len_d    = '0;
        ip_proto_d  = '0;
        icmp_type_d = '0;
      end else begin
        offset_d    = (o == OFF_MAX) ? o : o + OFFSET_WIDTH'(1);
        etype_d     = upd_etype;
        hdr_ok_d    = upd_hdr_ok;
        mac_d       = upd_mac;
        src_ip_d    = upd_src_ip;
        dst_ip_d    = upd_dst_ip;
        ip_len_d    = upd_ip_len;
        ip_proto_d  = upd_ip_proto;
        icmp_type_d = upd_icmp_type;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= '0;
      etype_q     <= '0;
      hdr_ok_q    <= 1'b1;
      mac_q       <= '0;
      src_ip_q    <= '0;
      dst_ip_q    <= '0;
      ip_len_q    <= '0;
      ip_proto_q  <= '0;
      icmp_type_q <= '0;
    end else begin
      offset_q    <= offset_d;
      etype_q     <= etype_d;
      hdr_ok_q    <= hdr_ok_d;
      mac_q       <= mac_d;
      src_ip_q    <= src_ip_d;
      dst_ip_q    <= dst_ip_d;
      ip_len_q    <= ip_len_d;
      ip_proto_q  <= ip_proto_d;
      icmp_type_q <= icmp_type_d;
    end
  end

endmodule

@@ src/arp_icmp_frame_classifier_core.sv @@
// Top level of the ARP and ICMP echo frame classifier with its configuration port.
//
// The block takes one frame byte per beat on rx_i, starting at the destination MAC, and
// gives one verdict on verdict_o for every byte marked frame_end: ignore, ARP reply due
// (with the sender MAC and IP) or ICMP echo reply due (with the source IP and the ICMP
// length, IPv4 total length minus 20). It takes one byte every clock cycle while rx_i is
// not stalled; a byte passes an input register and then the parser, and the verdict is
// registered in the output register. A verdict that waits on verdict_o stalls rx_i
// only when a further last byte reaches the parser. The byte counter saturates at
// 2**OFFSET_WIDTH - 1. Our IPv4 address sits at byte address 0 of the APB port, resets
// to 172.22.26.219 and should be written only between frames.
module arp_icmp_frame_classifier_core #(
  parameter int unsigned OFFSET_WIDTH = aic_pkg::OFFSET_WIDTH_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  aic_rx_if.sink                             rx_i,
  aic_verdict_if.source                      verdict_o,
  input  logic                               psel_i,
  input  logic                               penable_i,
  input  logic                               pwrite_i,
  input  logic [aic_pkg::APB_ADDR_WIDTH-1:0] paddr_i,
  input  logic [aic_pkg::APB_DATA_WIDTH-1:0] pwdata_i,
  output logic [aic_pkg::APB_DATA_WIDTH-1:0] prdata_o,
  output logic                               pready_o
);

  // Configuration register.
  logic [31:0] local_ip_q;
  logic        cfg_wr;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && (paddr_i[2] == aic_pkg::REG_LOCAL_IP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_ip_q <= aic_pkg::LOCAL_IP_RESET;
    end else if (cfg_wr) begin
      local_ip_q <= pwdata_i[31:0];
    end
  end

  always_comb begin
    prdata_o = '0;
    if (paddr_i[2] == aic_pkg::REG_LOCAL_IP) begin
      prdata_o = local_ip_q;
    end
  end

  // Input register stage.
  logic       s1_valid_q;
  logic       s1_last_q;
  logic [7:0] s1_byte_q;
  logic       s1_adv;
  logic       out_free;
  logic       rx_fire;

  assign out_free   = !verdict_o.valid || verdict_o.ready;
  assign s1_adv     = s1_valid_q && (!s1_last_q || out_free);
  assign rx_i.ready = !s1_valid_q || s1_adv;
  assign rx_fire    = rx_i.valid && rx_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      s1_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_fire) begin
      s1_byte_q <= rx_i.rx_byte;
      s1_last_q <= rx_i.frame_end;
    end
  end

  // Header parser.
  aic_pkg::aic_beat_t    beat;
  aic_pkg::aic_verdict_t verdict;

  assign beat = '{valid: s1_adv, last: s1_last_q, data: s1_byte_q};

  aic_parser #(
    .OFFSET_WIDTH(OFFSET_WIDTH)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .beat_i     (beat),
    .local_ip_i (local_ip_q),
    .verdict_o  (verdict)
  );

  // Verdict output register.
  logic                  out_valid_q;
  aic_pkg::aic_verdict_t out_q;
  logic                  out_load;

  assign out_load = s1_adv && s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (verdict_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= verdict;
    end
  end

  assign verdict_o.valid       = out_valid_q;
  assign verdict_o.action      = out_q.action;
  assign verdict_o.sender_mac  = out_q.sender_mac;
  assign verdict_o.sender_ip   = out_q.sender_ip;
  assign verdict_o.echo_length = out_q.echo_length;

  // A held byte in the input register is neither lost nor altered.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_byte_q) && $stable(s1_last_q))
    else $error("input register lost or changed a stalled byte");

  // Input backpressure arises only from a last byte blocked by a waiting verdict.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_i.ready |-> s1_valid_q && s1_last_q && out_valid_q && !verdict_o.ready)
    else $error("input stalled without a blocked verdict");

  // A new verdict appears only after a last byte went through the parser.
  a_verdict_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_adv && s1_last_q))
    else $error("verdict without a frame end");

  // ARP verdicts carry no echo length; echo verdicts carry no MAC.
  a_field_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.action != aic_pkg::ACT_ARP || out_q.echo_length == '0) &&
                    (out_q.action != aic_pkg::ACT_ECHO || out_q.sender_mac == '0))
    else $error("verdict carries a field of the wrong reply type");

  // An ignore verdict carries all fields zero.
  a_ignore_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.action == aic_pkg::ACT_IGNORE |->
      out_q.sender_mac == '0 && out_q.sender_ip == '0 && out_q.echo_length == '0)
    else $error("ignore verdict with nonzero fields");

endmodule

@@ tb/arp_icmp_frame_classifier_core_tb.sv @@
// Self-checking testbench for the ARP and ICMP echo frame classifier core.
module arp_icmp_frame_classifier_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aic_pkg::*;

  localparam int unsigned OFFSET_WIDTH = OFFSET_WIDTH_DEFAULT;
  localparam int unsigned MAX_OFFSET = (1 << OFFSET_WIDTH) - 1;
  localparam int unsigned ARP_MIN_FRAME = ARP_MIN_LAST_OFF + 1;
  localparam int unsigned IPV4_MIN_FRAME = IPV4_MIN_LAST_OFF + 1;
  // Bytes 14..21 of an ARP request for IPv4 over Ethernet, first byte in the top lane.
  localparam logic [63:0] ARP_REQUEST_HDR = 64'h0001_0800_0604_0001;
  localparam logic [APB_ADDR_WIDTH-1:0] LOCAL_IP_ADDR = APB_ADDR_WIDTH'(4 * REG_LOCAL_IP);
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES = 4;
  localparam int FRAMES_PER_PHASE = 16;
  localparam int NUM_DIRECTED = 21;

  typedef enum logic [1:0] {FK_ARP, FK_IPV4, FK_OTHER, FK_NOISE} frame_kind_e;
  typedef enum logic [2:0] {
    FL_NONE, FL_ARP_HDR, FL_IP_VER, FL_IP_FLAGS, FL_IP_FRAG_LO, FL_IP_PROTO, FL_ICMP_TYPE
  } frame_flaw_e;
  typedef enum logic [1:0] {SP_STEADY, SP_COIN, SP_EVERY_FOURTH} sink_pattern_e;

  // One frame to send; typed rows carry the verdict that is obvious from the row.
  typedef struct {
    frame_kind_e kind;
    int          len;
    frame_flaw_e flaw;
    bit          df;
    logic [47:0] mac;
    logic [31:0] sip;
    logic [31:0] tip;
    logic [15:0] tot_len;
    bit          typed;
    action_e     act;
  } frame_spec_t;

  typedef struct {
    bit           known;
    aic_verdict_t v;
  } verdict_plan_t;

  logic clk_i;
  logic rst_ni;
  logic psel_i;
  logic penable_i;
  logic pwrite_i;
  logic [APB_ADDR_WIDTH-1:0] paddr_i;
  logic [APB_DATA_WIDTH-1:0] pwdata_i;
  logic [APB_DATA_WIDTH-1:0] prdata_o;
  logic pready_o;

  aic_rx_if      rx ();
  aic_verdict_if vd ();

  arp_icmp_frame_classifier_core #(
    .OFFSET_WIDTH(OFFSET_WIDTH)
  ) uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rx_i     (rx),
    .verdict_o(vd),
    .psel_i   (psel_i),
    .penable_i(penable_i),
    .pwrite_i (pwrite_i),
    .paddr_i  (paddr_i),
    .pwdata_i (pwdata_i),
    .prdata_o (prdata_o),
    .pready_o (pready_o)
  );

  // Shadow of the classifier's per-frame state and of our address register.
  logic [31:0] our_ip = LOCAL_IP_RESET;
  logic [OFFSET_WIDTH-1:0] cls_offset;
  logic [15:0] cls_etype;
  logic        cls_hdr_ok;
  logic [47:0] cls_mac;
  logic [31:0] cls_sip;
  logic [31:0] cls_tip;
  logic [15:0] cls_tot_len;
  logic [7:0]  cls_proto;
  logic [8:0]  cls_icmp;

  aic_verdict_t  expected_verdicts [$];
  verdict_plan_t frame_plan [$];
  logic [7:0]    frame_bytes [$];

  int mismatches = 0;
  int frames_sent = 0;
  int bytes_sent = 0;
  int arp_verdicts = 0;
  int echo_verdicts = 0;
  int ignore_verdicts = 0;
  int burst_left = 0;
  bit hold_off_req = 1'b0;

  // Directed frames; the typed verdict applies where the outcome is plain from the row.
  frame_spec_t directed_frames [NUM_DIRECTED] = '{
    // Minimum-length ARP request for our reset address.
    '{FK_ARP, 42, FL_NONE, 1'b0, 48'h02005E102030, 32'hC0A80001, LOCAL_IP_RESET,
      16'h0, 1'b1, ACT_ARP},
    // One byte short of a full ARP packet.
    '{FK_ARP, 41, FL_NONE, 1'b0, 48'h02005E102030, 32'hC0A80001, LOCAL_IP_RESET,
      16'h0, 1'b1, ACT_IGNORE},
    '{FK_ARP, 64, FL_NONE, 1'b0, 48'hFFFFFFFFFFFF, 32'hFFFFFFFF, LOCAL_IP_RESET,
      16'h0, 1'b1, ACT_ARP},
    '{FK_ARP, 60, FL_NONE, 1'b0, 48'h0, 32'h0, LOCAL_IP_RESET, 16'h0, 1'b1, ACT_ARP},
    '{FK_ARP, 60, FL_ARP_HDR, 1'b0, 48'h02005E102030, 32'hC0A80001, LOCAL_IP_RESET,
      16'h0, 1'b1, ACT_IGNORE},
    '{FK_ARP, 60, FL_NONE, 1'b0, 48'h02005E102030, 32'hC0A80001, LOCAL_IP_RESET ^ 32'h1,
      16'h0, 1'b1, ACT_IGNORE},
    // Shortest echo request that carries the ICMP type byte.
    '{FK_IPV4, 35, FL_NONE, 1'b0, 48'h0, 32'h0A000001, LOCAL_IP_RESET, 16'd28, 1'b1, ACT_ECHO},
    // Frame ends before the ICMP type byte.
    '{FK_IPV4, 34, FL_NONE, 1'b0, 48'h0, 32'h0A000001, LOCAL_IP_RESET, 16'd28, 1'b1, ACT_IGNORE},
    '{FK_IPV4, 33, FL_NONE, 1'b0, 48'h0, 32'h0A000001, LOCAL_IP_RESET, 16'd28, 1'b1, ACT_IGNORE},
    // Total length under the header size, which wraps the echo length, and the maximum total length.
    '{FK_IPV4, 64, FL_NONE, 1'b1, 48'h0, 32'h0, LOCAL_IP_RESET, 16'd0, 1'b0, ACT_IGNORE},
    '{FK_IPV4, 98, FL_NONE, 1'b1, 48'h0, 32'hFFFFFFFF, LOCAL_IP_RESET, 16'hFFFF, 1'b0, ACT_IGNORE},
    '{FK_IPV4, 64, FL_IP_FLAGS, 1'b0, 48'h0, 32'h0A000001, LOCAL_IP_RESET, 16'd50, 1'b1,
      ACT_IGNORE},
    '{FK_IPV4, 64, FL_IP_FRAG_LO, 1'b1, 48'h0, 32'h0A000001, LOCAL_IP_RESET, 16'd50, 1'b1,
      ACT_IGNORE},
    '{FK_IPV4, 64, FL_IP_VER, 1'b0, 48'h0, 32'h0A000001, LOCAL_IP_RESET, 16'd50, 1'b1,
      ACT_IGNORE},
    '{FK_IPV4, 64, FL_IP_PROTO, 1'b0, 48'h0, 32'h0A000001, LOCAL_IP_RESET, 16'd50, 1'b1,
      ACT_IGNORE},
    '{FK_IPV4, 64, FL_ICMP_TYPE, 1'b0, 48'h0, 32'h0A000001, LOCAL_IP_RESET, 16'd50, 1'b1,
      ACT_IGNORE},
    '{FK_IPV4, 64, FL_NONE, 1'b0, 48'h0, 32'h0A000001, LOCAL_IP_RESET ^ 32'h80000000,
      16'd50, 1'b1, ACT_IGNORE},
    // Unknown ethertype, a one-byte frame, and a frame that stops at the ethertype.
    '{FK_OTHER, 60, FL_NONE, 1'b0, 48'h0, 32'h0, LOCAL_IP_RESET, 16'h0, 1'b1, ACT_IGNORE},
    '{FK_NOISE, 1, FL_NONE, 1'b0, 48'h0, 32'h0, LOCAL_IP_RESET, 16'h0, 1'b1, ACT_IGNORE},
    '{FK_ARP, 14, FL_NONE, 1'b0, 48'h0, 32'h0, LOCAL_IP_RESET, 16'h0, 1'b1, ACT_IGNORE},
    // A frame long enough to saturate the byte counter.
    '{FK_ARP, 2100, FL_NONE, 1'b0, 48'h0A0B0C0D0E0F, 32'h01020304, LOCAL_IP_RESET,
      16'h0, 1'b0, ACT_IGNORE}
  };

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Clears the per-frame part of the shadow state.
  function automatic void clear_frame_state();
    cls_offset  = '0;
    cls_etype   = '0;
    cls_hdr_ok  = 1'b1;
    cls_mac     = '0;
    cls_sip     = '0;
    cls_tip     = '0;
    cls_tot_len = '0;
    cls_proto   = '0;
    cls_icmp    = '0;
  endfunction

  // Advances the shadow classifier by one byte; returns 1 with a verdict on the last byte.
  function automatic bit classify_byte(input logic [7:0] b, input logic last,
                                       output aic_verdict_t v);
    int unsigned o;
    int unsigned frame_len;
    o = cls_offset;
    v = '0;
    if (o == OFF_ETYPE_HI || o == OFF_ETYPE_LO) begin
      cls_etype = {cls_etype[7:0], b};
    end else if (cls_etype == ETYPE_ARP) begin
      if (o >= OFF_ARP_FIX_LO && o <= OFF_ARP_FIX_HI) begin
        if (b != ARP_REQUEST_HDR[8*(OFF_ARP_FIX_HI - o) +: 8]) cls_hdr_ok = 1'b0;
      end else if (o >= OFF_ARP_SHA_LO && o <= OFF_ARP_SHA_HI) begin
        cls_mac = {cls_mac[39:0], b};
      end else if (o >= OFF_ARP_SPA_LO && o <= OFF_ARP_SPA_HI) begin
        cls_sip = {cls_sip[23:0], b};
      end else if (o >= OFF_ARP_TPA_LO && o <= OFF_ARP_TPA_HI) begin
        cls_tip = {cls_tip[23:0], b};
      end
    end else if (cls_etype == ETYPE_IPV4) begin
      if (o == OFF_IP_VER) begin
        if (b != IPV4_FIRST_BYTE) cls_hdr_ok = 1'b0;
      end else if (o == OFF_IP_LEN_HI || o == OFF_IP_LEN_LO) begin
        cls_tot_len = {cls_tot_len[7:0], b};
      end else if (o == OFF_IP_FLAGS_HI) begin
        if ((b & DF_ONLY_MASK) != 8'h00) cls_hdr_ok = 1'b0;
      end else if (o == OFF_IP_FLAGS_LO) begin
        if (b != 8'h00) cls_hdr_ok = 1'b0;
      end else if (o == OFF_IP_PROTO) begin
        cls_proto = b;
      end else if (o >= OFF_IP_SRC_LO && o <= OFF_IP_SRC_HI) begin
        cls_sip = {cls_sip[23:0], b};
      end else if (o >= OFF_IP_DST_LO && o <= OFF_IP_DST_HI) begin
        cls_tip = {cls_tip[23:0], b};
      end else if (o == OFF_ICMP_TYPE) begin
        cls_icmp = {1'b1, b};
      end
    end

    if (!last) begin
      if (o < MAX_OFFSET) cls_offset = cls_offset + 1'b1;
      return 1'b0;
    end

    // Verdict on the last byte, then a fresh frame.
    frame_len = o + 1;
    if (cls_etype == ETYPE_ARP && frame_len >= ARP_MIN_FRAME && cls_hdr_ok &&
        cls_tip == our_ip) begin
      v.action     = ACT_ARP;
      v.sender_mac = cls_mac;
      v.sender_ip  = cls_sip;
    end else if (cls_etype == ETYPE_IPV4 && frame_len >= IPV4_MIN_FRAME && cls_hdr_ok &&
                 cls_tip == our_ip && cls_proto == IP_PROTO_ICMP &&
                 cls_icmp == {1'b1, ICMP_ECHO_REQ}) begin
      v.action      = ACT_ECHO;
      v.sender_ip   = cls_sip;
      v.echo_length = cls_tot_len - IPV4_HDR_BYTES;
    end
    clear_frame_state();
    return 1'b1;
  endfunction

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Overwrites a byte of the frame being built, if the frame reaches that far.
  function automatic void put_byte(input int off, input logic [7:0] val);
    if (off < frame_bytes.size()) frame_bytes[off] = val;
  endfunction

  // Fills frame_bytes with random content and lays the requested header over it.
  function automatic void build_frame(input frame_spec_t s);
    logic [15:0] etype;
    logic [7:0]  val;
    int          k;
    frame_bytes.delete();
    for (int i = 0; i < s.len; i++) frame_bytes.push_back(8'($urandom));
    case (s.kind)
      FK_ARP: begin
        put_byte(OFF_ETYPE_HI, ETYPE_ARP[15:8]);
        put_byte(OFF_ETYPE_LO, ETYPE_ARP[7:0]);
        for (int i = 0; i < 8; i++) put_byte(OFF_ARP_FIX_LO + i, ARP_REQUEST_HDR[8*(7-i) +: 8]);
        for (int i = 0; i < 6; i++) put_byte(OFF_ARP_SHA_LO + i, s.mac[8*(5-i) +: 8]);
        for (int i = 0; i < 4; i++) begin
          put_byte(OFF_ARP_SPA_LO + i, s.sip[8*(3-i) +: 8]);
          put_byte(OFF_ARP_TPA_LO + i, s.tip[8*(3-i) +: 8]);
        end
        if (s.flaw == FL_ARP_HDR) begin
          k = $urandom_range(0, 7);
          put_byte(OFF_ARP_FIX_LO + k,
                   ARP_REQUEST_HDR[8*(7-k) +: 8] ^ (8'h01 << $urandom_range(0, 7)));
        end
      end
      FK_IPV4: begin
        put_byte(OFF_ETYPE_HI, ETYPE_IPV4[15:8]);
        put_byte(OFF_ETYPE_LO, ETYPE_IPV4[7:0]);
        put_byte(OFF_IP_VER, IPV4_FIRST_BYTE);
        put_byte(OFF_IP_LEN_HI, s.tot_len[15:8]);
        put_byte(OFF_IP_LEN_LO, s.tot_len[7:0]);
        put_byte(OFF_IP_FLAGS_HI, s.df ? 8'h40 : 8'h00);
        put_byte(OFF_IP_FLAGS_LO, 8'h00);
        put_byte(OFF_IP_PROTO, IP_PROTO_ICMP);
        for (int i = 0; i < 4; i++) begin
          put_byte(OFF_IP_SRC_LO + i, s.sip[8*(3-i) +: 8]);
          put_byte(OFF_IP_DST_LO + i, s.tip[8*(3-i) +: 8]);
        end
        put_byte(OFF_ICMP_TYPE, ICMP_ECHO_REQ);
        case (s.flaw)
          FL_IP_VER: put_byte(OFF_IP_VER, IPV4_FIRST_BYTE ^ (8'h01 << $urandom_range(0, 7)));
          FL_IP_FLAGS: begin
            // Any flag or offset bit other than DF.
            k = $urandom_range(0, 6);
            if (k == 6) k = 7;
            put_byte(OFF_IP_FLAGS_HI, (s.df ? 8'h40 : 8'h00) | (8'h01 << k));
          end
          FL_IP_FRAG_LO: put_byte(OFF_IP_FLAGS_LO, 8'($urandom_range(1, 255)));
          FL_IP_PROTO: begin
            val = 8'($urandom);
            if (val == IP_PROTO_ICMP) val = 8'h06;
            put_byte(OFF_IP_PROTO, val);
          end
          FL_ICMP_TYPE: begin
            val = 8'($urandom);
            if (val == ICMP_ECHO_REQ) val = 8'h00;
            put_byte(OFF_ICMP_TYPE, val);
          end
          default: ;
        endcase
      end
      FK_OTHER: begin
        etype = 16'($urandom);
        if (etype == ETYPE_ARP || etype == ETYPE_IPV4) etype = 16'h86DD;
        put_byte(OFF_ETYPE_HI, etype[15:8]);
        put_byte(OFF_ETYPE_LO, etype[7:0]);
      end
      default: ;
    endcase
  endfunction

  // Random frame: mostly well-formed requests with random content, some flawed or noise.
  function automatic frame_spec_t rand_frame_spec();
    frame_spec_t s;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    s.kind = (pick < 40) ? FK_ARP : (pick < 80) ? FK_IPV4 : (pick < 90) ? FK_OTHER : FK_NOISE;
    pick = $urandom_range(0, 99);
    if (pick < 3) s.len = $urandom_range(2040, 2100);
    else if (pick < 15) s.len = $urandom_range(1, 41);
    else if (s.kind == FK_IPV4) s.len = $urandom_range(34, 64);
    else s.len = $urandom_range(42, 64);
    s.flaw = FL_NONE;
    if ($urandom_range(0, 3) == 0) begin
      if (s.kind == FK_ARP) s.flaw = FL_ARP_HDR;
      else if (s.kind == FK_IPV4) s.flaw = frame_flaw_e'($urandom_range(FL_IP_VER, FL_ICMP_TYPE));
    end
    s.df  = 1'($urandom);
    s.mac = {16'($urandom), 32'($urandom)};
    s.sip = $urandom;
    pick = $urandom_range(0, 9);
    if (pick < 8) s.tip = our_ip;
    else if (pick < 9) s.tip = $urandom;
    else s.tip = our_ip ^ (32'h1 << $urandom_range(0, 31));
    case ($urandom_range(0, 3))
      0, 1:    s.tot_len = 16'(s.len - 14);
      2:       s.tot_len = 16'($urandom);
      default: s.tot_len = 16'($urandom_range(0, 19));
    endcase
    s.typed = 1'b0;
    s.act   = ACT_IGNORE;
    return s;
  endfunction

  // Offers one byte, with a random gap when a burst runs out, and waits for the beat.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      burst_left = $urandom_range(1, 60);
      if (gap > 0) begin
        rx.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    rx.valid     <= 1'b1;
    rx.rx_byte   <= b;
    rx.frame_end <= last;
    do @(posedge clk_i); while (!rx.ready);
  endtask

  // Sends one frame and records the typed verdict where the row gives one.
  task automatic send_frame(input frame_spec_t s);
    verdict_plan_t plan;
    build_frame(s);
    plan.known = s.typed;
    plan.v = '0;
    plan.v.action = s.act;
    if (s.act == ACT_ARP) begin
      plan.v.sender_mac = s.mac;
      plan.v.sender_ip  = s.sip;
    end else if (s.act == ACT_ECHO) begin
      plan.v.sender_ip   = s.sip;
      plan.v.echo_length = s.tot_len - IPV4_HDR_BYTES;
    end
    frame_plan.push_back(plan);
    for (int i = 0; i < frame_bytes.size(); i++) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    frames_sent++;
    bytes_sent += frame_bytes.size();
  endtask

  // Waits until every frame sent so far has had its verdict, then lets the pipeline settle.
  task automatic wait_idle();
    rx.valid <= 1'b0;
    while (expected_verdicts.size() != 0 || frame_plan.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One APB transfer: setup cycle, then access until pready.
  task automatic apb_xfer(input logic wr, input logic [APB_DATA_WIDTH-1:0] wdata,
                          output logic [APB_DATA_WIDTH-1:0] rdata);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= wr;
    paddr_i   <= LOCAL_IP_ADDR;
    pwdata_i  <= wdata;
    @(posedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    rdata = prdata_o;
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
  endtask

  // Writes our address, reads it back and updates the shadow copy.
  task automatic set_local_ip(input logic [31:0] value);
    logic [APB_DATA_WIDTH-1:0] rdata;
    apb_xfer(1'b1, value, rdata);
    apb_xfer(1'b0, '0, rdata);
    if (rdata !== value) report_mismatch("local address readback", rdata, value);
    our_ip = value;
  endtask

  // Receiver: changes its ready pattern from time to time and honors one long hold-off.
  initial begin
    sink_pattern_e pattern;
    int pattern_left;
    int cycle;
    pattern = SP_STEADY;
    pattern_left = 0;
    cycle = 0;
    vd.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        vd.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else begin
        if (pattern_left == 0) begin
          pattern = sink_pattern_e'($urandom_range(SP_STEADY, SP_EVERY_FOURTH));
          pattern_left = $urandom_range(32, 200);
        end
        pattern_left--;
        cycle++;
        case (pattern)
          SP_STEADY: vd.ready <= 1'b1;
          SP_COIN:   vd.ready <= 1'($urandom);
          default:   vd.ready <= (cycle % 4 == 0);
        endcase
      end
    end
  end

  // Monitor: checks each verdict beat against the oldest expectation, predicts on each byte.
  always @(posedge clk_i) begin : monitor
    aic_verdict_t  got;
    aic_verdict_t  want;
    aic_verdict_t  predicted;
    verdict_plan_t plan;
    if (rst_ni) begin
      if (vd.valid && vd.ready) begin
        got.action      = action_e'(vd.action);
        got.sender_mac  = vd.sender_mac;
        got.sender_ip   = vd.sender_ip;
        got.echo_length = vd.echo_length;
        if (expected_verdicts.size() == 0) begin
          report_mismatch("verdict with no frame pending, action", got.action, '0);
        end else begin
          want = expected_verdicts.pop_front();
          if (got.action != want.action) report_mismatch("action", got.action, want.action);
          if (got.sender_mac != want.sender_mac)
            report_mismatch("sender_mac", got.sender_mac, want.sender_mac);
          if (got.sender_ip != want.sender_ip)
            report_mismatch("sender_ip", got.sender_ip, want.sender_ip);
          if (got.echo_length != want.echo_length)
            report_mismatch("echo_length", got.echo_length, want.echo_length);
          case (want.action)
            ACT_ARP:  arp_verdicts++;
            ACT_ECHO: echo_verdicts++;
            default:  ignore_verdicts++;
          endcase
        end
      end
      if (rx.valid && rx.ready) begin
        if (classify_byte(rx.rx_byte, rx.frame_end, predicted)) begin
          if (frame_plan.size() != 0) begin
            plan = frame_plan.pop_front();
            expected_verdicts.push_back(plan.known ? plan.v : predicted);
          end else begin
            expected_verdicts.push_back(predicted);
          end
        end
      end
    end
  end

  // Watchdog: ends the run when no beat moves on either channel for too long.
  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (rx.valid && rx.ready) || (vd.valid && vd.ready)) idle = 0;
      else idle++;
    end
    $display("Watchdog: no beat for %0d cycles, %0d verdicts outstanding",
             STALL_LIMIT, expected_verdicts.size());
    $display("status: fail");
    $finish;
  end

  // Main sequence: reset, directed frames, then random phases under several addresses.
  initial begin
    logic [APB_DATA_WIDTH-1:0] rdata;
    logic [31:0] phase_ips [4];
    rst_ni       <= 1'b0;
    rx.valid     <= 1'b0;
    rx.rx_byte   <= '0;
    rx.frame_end <= 1'b0;
    psel_i       <= 1'b0;
    penable_i    <= 1'b0;
    pwrite_i     <= 1'b0;
    paddr_i      <= '0;
    pwdata_i     <= '0;
    clear_frame_state();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The address register must come up at its reset value.
    apb_xfer(1'b0, '0, rdata);
    if (rdata !== LOCAL_IP_RESET) report_mismatch("local address after reset", rdata,
                                                  LOCAL_IP_RESET);

    for (int i = 0; i < NUM_DIRECTED; i++) send_frame(directed_frames[i]);
    wait_idle();

    // Random phases at the address extremes, a random address and back to the default.
    phase_ips = '{32'h0000_0000, 32'hFFFF_FFFF, 32'($urandom), LOCAL_IP_RESET};
    for (int phase = 0; phase < 4; phase++) begin
      set_local_ip(phase_ips[phase]);
      if (phase == 1) hold_off_req = 1'b1;
      repeat (FRAMES_PER_PHASE) send_frame(rand_frame_spec());
      wait_idle();
    end
    repeat (8) @(posedge clk_i);

    $display("Sent %0d frames (%0d bytes) under 5 address settings, incl. saturating frames.",
             frames_sent, bytes_sent);
    $display("Checked %0d ARP, %0d echo and %0d ignore verdicts; %0d mismatches.",
             arp_verdicts, echo_verdicts, ignore_verdicts, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ arp_icmp_frame_classifier_core.f @@
src/aic_pkg.sv
src/aic_if.sv
src/aic_parser.sv
src/arp_icmp_frame_classifier_core.sv
tb/arp_icmp_frame_classifier_core_tb.sv
